/* design/esc_pkg.sv */
// Shared types and constants for the environmental sensor compensation pipeline.
// Holds the decoded coefficient set, the side data carried past the divider and
// the configuration register indexes. No dependencies.
package esc_pkg;

  localparam int DIV_STAGES = 32;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_9 = 3'd3,
    REG_HUM_A   = 3'd4,
    REG_HUM_B   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] p3;
    logic signed [31:0] p4;
    logic signed [31:0] p5;
    logic signed [31:0] p6;
    logic signed [31:0] p7;
    logic signed [31:0] p8;
    logic signed [31:0] p9;
    logic signed [31:0] h1;
    logic signed [31:0] h2;
    logic signed [31:0] h3;
    logic signed [31:0] h4;
    logic signed [31:0] h5;
    logic signed [31:0] h6;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [16:0]        humidity;
    logic               zero;
    logic               dbl;
  } side_t;

endpackage

/* design/esc_front.sv */
// Front pipeline: temperature, humidity and the pressure dividend and divisor.
// Fourteen register stages with at most one multiplier level per stage. Uses esc_pkg.
module esc_front import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [19:0]        adc_temp,
  input  logic [19:0]        adc_press,
  input  logic [15:0]        adc_hum,
  input  coef_t              coef,
  output logic               out_valid,
  output logic [31:0]        dividend,
  output logic [31:0]        divisor,
  output side_t              side
);

  logic               vld_r [1:14];
  logic [19:0]        ap_r  [1:7];
  logic [15:0]        ah_r  [1:5];
  logic signed [31:0] tmp_r [4:14];
  logic signed [31:0] ha_r  [6:10];
  logic [31:0]        dvd_r [10:14];
  logic [31:0]        dvs_r [10:14];
  logic               dbl_r [10:14];
  logic               zro_r [10:14];
  logic signed [31:0] hx_r  [11:13];

  logic signed [31:0] s1_m1_r, s1_m2_r;
  logic signed [31:0] s2_a_r, s2_m3_r;
  logic signed [31:0] s3_tf_r;
  logic signed [31:0] s4_pa_r, s4_hx_r;
  logic signed [31:0] s5_pd_r, s5_mp5_r, s5_mp2_r, s5_mh5_r, s5_mh6_r, s5_mh3_r;
  logic signed [31:0] s6_b1_r, s6_mp3_r, s6_mp5_r, s6_mp2_r, s6_hb_r, s6_hc_r;
  logic signed [31:0] s7_b_r, s7_aa_r, s7_hbc_r;
  logic signed [31:0] s8_am_r, s8_num_r, s8_hd_r;
  logic signed [31:0] s9_div_r, s9_pn_r, s9_hdm_r;
  logic signed [31:0] s10_hd2_r;
  logic signed [31:0] s12_hsq_r;
  logic signed [31:0] s13_hm_r;
  logic [16:0]        s14_hum_r;

  logic signed [31:0] d1, pq, hq, hf, ah32;

  always_comb begin
    d1   = $signed({16'b0, adc_temp[19:4]}) - coef.t1;
    pq   = s4_pa_r >>> 2;
    hq   = hx_r[11] >>> 15;
    hf   = hx_r[13] - (s13_hm_r >>> 4);
    ah32 = $signed({2'b0, ah_r[5], 14'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 14; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= in_valid;
      for (int k = 2; k <= 14; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ap_r[1] <= adc_press;
      for (int k = 2; k <= 7; k++) ap_r[k] <= ap_r[k-1];
      ah_r[1] <= adc_hum;
      for (int k = 2; k <= 5; k++) ah_r[k] <= ah_r[k-1];

      s1_m1_r <= ($signed({15'b0, adc_temp[19:3]}) - (coef.t1 <<< 1)) * coef.t2;
      s1_m2_r <= d1 * d1;

      s2_a_r  <= s1_m1_r >>> 11;
      s2_m3_r <= (s1_m2_r >>> 12) * coef.t3;

      s3_tf_r <= s2_a_r + (s2_m3_r >>> 14);

      tmp_r[4] <= (s3_tf_r * 32'sd5 + 32'sd128) >>> 8;
      for (int k = 5; k <= 14; k++) tmp_r[k] <= tmp_r[k-1];
      s4_pa_r <= (s3_tf_r >>> 1) - 32'sd64000;
      s4_hx_r <= s3_tf_r - 32'sd76800;

      s5_pd_r  <= pq * pq;
      s5_mp5_r <= s4_pa_r * coef.p5;
      s5_mp2_r <= coef.p2 * s4_pa_r;
      s5_mh5_r <= coef.h5 * s4_hx_r;
      s5_mh6_r <= s4_hx_r * coef.h6;
      s5_mh3_r <= s4_hx_r * coef.h3;

      s6_b1_r  <= (s5_pd_r >>> 11) * coef.p6;
      s6_mp3_r <= coef.p3 * (s5_pd_r >>> 13);
      s6_mp5_r <= s5_mp5_r;
      s6_mp2_r <= s5_mp2_r;
      ha_r[6]  <= (ah32 - (coef.h4 <<< 20) - s5_mh5_r + 32'sd16384) >>> 15;
      for (int k = 7; k <= 10; k++) ha_r[k] <= ha_r[k-1];
      s6_hb_r  <= s5_mh6_r >>> 10;
      s6_hc_r  <= (s5_mh3_r >>> 11) + 32'sd32768;

      s7_b_r   <= ((s6_b1_r + (s6_mp5_r <<< 1)) >>> 2) + (coef.p4 <<< 16);
      s7_aa_r  <= ((s6_mp3_r >>> 3) + (s6_mp2_r >>> 1)) >>> 18;
      s7_hbc_r <= s6_hb_r * s6_hc_r;

      s8_am_r  <= (32'sd32768 + s7_aa_r) * coef.p1;
      s8_num_r <= (32'sd1048576 - $signed({12'b0, ap_r[7]})) - (s7_b_r >>> 12);
      s8_hd_r  <= (s7_hbc_r >>> 10) + 32'sd2097152;

      s9_div_r <= s8_am_r >>> 15;
      s9_pn_r  <= s8_num_r * 32'sd3125;
      s9_hdm_r <= s8_hd_r * coef.h2;

      s10_hd2_r <= (s9_hdm_r + 32'sd8192) >>> 14;
      dvd_r[10] <= s9_pn_r[31] ? s9_pn_r : (s9_pn_r <<< 1);
      dbl_r[10] <= s9_pn_r[31];
      dvs_r[10] <= s9_div_r;
      zro_r[10] <= (s9_div_r == 32'sd0);
      for (int k = 11; k <= 14; k++) begin
        dvd_r[k] <= dvd_r[k-1];
        dvs_r[k] <= dvs_r[k-1];
        dbl_r[k] <= dbl_r[k-1];
        zro_r[k] <= zro_r[k-1];
      end

      hx_r[11] <= ha_r[10] * s10_hd2_r;
      for (int k = 12; k <= 13; k++) hx_r[k] <= hx_r[k-1];

      s12_hsq_r <= hq * hq;
      s13_hm_r  <= (s12_hsq_r >>> 7) * coef.h1;

      if (hf < 32'sd0) begin
        s14_hum_r <= 17'd0;
      end else if (hf > 32'sd419430400) begin
        s14_hum_r <= 17'd102400;
      end else begin
        s14_hum_r <= hf[28:12];
      end
    end
  end

  assign out_valid        = vld_r[14];
  assign dividend         = dvd_r[14];
  assign divisor          = dvs_r[14];
  assign side.temperature = tmp_r[14];
  assign side.humidity    = s14_hum_r;
  assign side.zero        = zro_r[14];
  assign side.dbl         = dbl_r[14];

endmodule

/* design/esc_div.sv */
// Pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage.
// Carries the side data of each item alongside. Uses esc_pkg.
module esc_div import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] quotient,
  output side_t       out_side
);

  logic        vld [0:DIV_STAGES];
  logic [31:0] rem [0:DIV_STAGES];
  logic [31:0] num [0:DIV_STAGES];
  logic [31:0] dvs [0:DIV_STAGES];
  side_t       sd  [0:DIV_STAGES];

  assign vld[0] = in_valid;
  assign rem[0] = 32'd0;
  assign num[0] = dividend;
  assign dvs[0] = divisor;
  assign sd[0]  = in_side;

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stage
    logic [32:0] trial;
    logic        ge;
    logic        vld_r;
    logic [31:0] rem_r, num_r, dvs_r;
    side_t       sd_r;

    always_comb begin
      trial = {rem[g-1], num[g-1][31]};
      ge    = (trial >= {1'b0, dvs[g-1]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r <= ge ? 32'(trial - {1'b0, dvs[g-1]}) : trial[31:0];
        num_r <= {num[g-1][30:0], ge};
        dvs_r <= dvs[g-1];
        sd_r  <= sd[g-1];
      end
    end

    assign vld[g] = vld_r;
    assign rem[g] = rem_r;
    assign num[g] = num_r;
    assign dvs[g] = dvs_r;
    assign sd[g]  = sd_r;
  end

  assign out_valid = vld[DIV_STAGES];
  assign quotient  = num[DIV_STAGES];
  assign out_side  = sd[DIV_STAGES];

endmodule

/* design/esc_back.sv */
// Back pipeline: pressure correction after the division and the output register.
// Three register stages, the last one drives the result channel. Uses esc_pkg.
module esc_back import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [31:0]        quotient,
  input  side_t              in_side,
  input  coef_t              coef,
  output logic               out_valid,
  output logic signed [31:0] temperature,
  output logic [31:0]        pressure,
  output logic [16:0]        humidity
);

  logic               b1_vld_r, b2_vld_r, out_vld_r;
  side_t              b1_sd_r, b2_sd_r;
  logic [31:0]        b1_p_r, b1_ms_r, b2_p_r;
  logic signed [31:0] b1_m8_r, b2_c_r, b2_b_r;
  logic signed [31:0] tmp_out_r;
  logic [31:0]        prs_out_r;
  logic [16:0]        hum_out_r;

  logic [31:0]        p0, p3, p2;
  logic signed [31:0] corr;

  always_comb begin
    p0   = in_side.dbl ? {quotient[30:0], 1'b0} : quotient;
    p3   = {3'b0, p0[31:3]};
    p2   = {2'b0, p0[31:2]};
    corr = ((b2_c_r >>> 12) + b2_b_r + coef.p7) >>> 4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r  <= in_valid;
      b2_vld_r  <= b1_vld_r;
      out_vld_r <= b2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sd_r <= in_side;
      b1_p_r  <= p0;
      b1_ms_r <= p3 * p3;
      b1_m8_r <= $signed(p2) * coef.p8;

      b2_sd_r <= b1_sd_r;
      b2_p_r  <= b1_p_r;
      b2_c_r  <= coef.p9 * $signed({13'b0, b1_ms_r[31:13]});
      b2_b_r  <= b1_m8_r >>> 13;

      tmp_out_r <= b2_sd_r.temperature;
      hum_out_r <= b2_sd_r.humidity;
      prs_out_r <= b2_sd_r.zero ? 32'd0 : 32'(b2_p_r + corr);
    end
  end

  assign out_valid   = out_vld_r;
  assign temperature = tmp_out_r;
  assign pressure    = prs_out_r;
  assign humidity    = hum_out_r;

endmodule

/* design/environmental_sensor_compensation.sv */
// Top level of the environmental sensor compensation pipeline: configuration
// registers, stall control and the front, divider and back sections.
// Depends on esc_pkg, esc_front, esc_div and esc_back.
//
//   Channel   Direction  Payload (lowest bit first)                 Width
//   in_       slave      adc_temp, adc_press, adc_hum              56
//   out_      master     temperature, pressure, humidity           88
//   cfg_      slave      register index and write data             3 + 64
//
// One sample triple is taken per cycle unless the output stalls; each result passes
// through 14 front stages, 32 divider stages and 3 back stages including the output.
// The divider, one quotient bit per stage, sets the depth.
// Reset clears the valid bits and the coefficients. When a result waits
// untaken the whole pipeline holds and in_tready falls.
module environmental_sensor_compensation import esc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [55:0]          in_tdata,   // adc_temp, adc_press, adc_hum
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [87:0]          out_tdata,  // temperature, pressure, humidity, zero fill
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [47:0] temp_r;
  logic [63:0] pa_r, pb_r;
  logic [15:0] p9_r;
  logic [39:0] ha_r;
  logic [23:0] hb_r;

  coef_t              coef;
  logic               adv;
  logic               f_vld, d_vld;
  logic [31:0]        f_dvd, f_dvs, d_q;
  side_t              f_sd, d_sd;
  logic signed [31:0] temperature;
  logic [31:0]        pressure;
  logic [16:0]        humidity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      pa_r   <= '0;
      pb_r   <= '0;
      p9_r   <= '0;
      ha_r   <= '0;
      hb_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP:    temp_r <= cfg_data[47:0];
        REG_PRESS_A: pa_r   <= cfg_data;
        REG_PRESS_B: pb_r   <= cfg_data;
        REG_PRESS_9: p9_r   <= cfg_data[15:0];
        REG_HUM_A:   ha_r   <= cfg_data[39:0];
        REG_HUM_B:   hb_r   <= cfg_data[23:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = $signed({16'b0, temp_r[15:0]});
    coef.t2 = 32'(signed'(temp_r[31:16]));
    coef.t3 = 32'(signed'(temp_r[47:32]));
    coef.p1 = $signed({16'b0, pa_r[15:0]});
    coef.p2 = 32'(signed'(pa_r[31:16]));
    coef.p3 = 32'(signed'(pa_r[47:32]));
    coef.p4 = 32'(signed'(pa_r[63:48]));
    coef.p5 = 32'(signed'(pb_r[15:0]));
    coef.p6 = 32'(signed'(pb_r[31:16]));
    coef.p7 = 32'(signed'(pb_r[47:32]));
    coef.p8 = 32'(signed'(pb_r[63:48]));
    coef.p9 = 32'(signed'(p9_r));
    coef.h1 = $signed({24'b0, ha_r[7:0]});
    coef.h2 = 32'(signed'(ha_r[23:8]));
    coef.h3 = $signed({24'b0, ha_r[31:24]});
    coef.h6 = 32'(signed'(ha_r[39:32]));
    coef.h4 = 32'(signed'(hb_r[11:0]));
    coef.h5 = 32'(signed'(hb_r[23:12]));
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  esc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .adc_temp  (in_tdata[19:0]),
    .adc_press (in_tdata[39:20]),
    .adc_hum   (in_tdata[55:40]),
    .coef      (coef),
    .out_valid (f_vld),
    .dividend  (f_dvd),
    .divisor   (f_dvs),
    .side      (f_sd)
  );

  esc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_vld),
    .dividend  (f_dvd),
    .divisor   (f_dvs),
    .in_side   (f_sd),
    .out_valid (d_vld),
    .quotient  (d_q),
    .out_side  (d_sd)
  );

  esc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (d_vld),
    .quotient    (d_q),
    .in_side     (d_sd),
    .coef        (coef),
    .out_valid   (out_tvalid),
    .temperature (temperature),
    .pressure    (pressure),
    .humidity    (humidity)
  );

  assign out_tdata = {7'b0, humidity, pressure, temperature};

  a_hum_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[80:64] <= 17'd102400)
    else $error("humidity above the clamp limit");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("pipeline moved while the result was stalled");

endmodule

/* test/tb_top.sv */
// Testbench for environmental_sensor_compensation: drives raw sample triples and
// coefficient sets, and checks each result against a predictor in this file or
// a fixed expected reading. Depends on esc_pkg and the design sources.
`timescale 1ns / 1ps

module tb_top;
  import esc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd6;
  localparam int PIPE_DEPTH = 49;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 110;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
  } reading_t;

  typedef struct {
    logic [19:0] at;
    logic [19:0] ap;
    logic [15:0] ah;
    bit          typed;
    reading_t    want;
  } sample_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [55:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [87:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  logic [63:0] coef_regs [6];
  reading_t    pending_readings [$];
  int          errors;
  bit          quiet;
  bit          hold_req;
  longint      cycles;

  environmental_sensor_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sfield(logic [63:0] v, int pos, int w);
    logic [31:0] m;
    logic [31:0] x;
    m = (32'd1 << w) - 32'd1;
    x = 32'(v >> pos) & m;
    if (x[w-1]) begin
      x = x | ~m;
    end
    return x;
  endfunction

  function automatic logic [31:0] ufield(logic [63:0] v, int pos, int w);
    return 32'(v >> pos) & ((32'd1 << w) - 32'd1);
  endfunction

  function automatic reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p,
                                          logic [15:0] adc_h);
    logic [31:0] at, ap, ah;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, c, d, tf, p, x;
    reading_t r;
    at = 32'(adc_t);
    ap = 32'(adc_p);
    ah = 32'(adc_h);
    t1 = ufield(coef_regs[REG_TEMP], 0, 16);
    t2 = sfield(coef_regs[REG_TEMP], 16, 16);
    t3 = sfield(coef_regs[REG_TEMP], 32, 16);
    p1 = ufield(coef_regs[REG_PRESS_A], 0, 16);
    p2 = sfield(coef_regs[REG_PRESS_A], 16, 16);
    p3 = sfield(coef_regs[REG_PRESS_A], 32, 16);
    p4 = sfield(coef_regs[REG_PRESS_A], 48, 16);
    p5 = sfield(coef_regs[REG_PRESS_B], 0, 16);
    p6 = sfield(coef_regs[REG_PRESS_B], 16, 16);
    p7 = sfield(coef_regs[REG_PRESS_B], 32, 16);
    p8 = sfield(coef_regs[REG_PRESS_B], 48, 16);
    p9 = sfield(coef_regs[REG_PRESS_9], 0, 16);
    h1 = ufield(coef_regs[REG_HUM_A], 0, 8);
    h2 = sfield(coef_regs[REG_HUM_A], 8, 16);
    h3 = ufield(coef_regs[REG_HUM_A], 24, 8);
    h6 = sfield(coef_regs[REG_HUM_A], 32, 8);
    h4 = sfield(coef_regs[REG_HUM_B], 0, 12);
    h5 = sfield(coef_regs[REG_HUM_B], 12, 12);

    a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    tf = a + b;
    r.temperature = sra(tf * 32'd5 + 32'd128, 8);

    a = sra(tf, 1) - 32'd64000;
    d = sra(a, 2) * sra(a, 2);
    b = sra(d, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(d, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    if (a == 32'd0) begin
      p = 32'd0;
    end else begin
      p = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) begin
        p = (p << 1) / a;
      end else begin
        p = (p / a) * 32'd2;
      end
      c = p9 * (((p >> 3) * (p >> 3)) >> 13);
      a = sra(c, 12);
      b = sra((p >> 2) * p8, 13);
      p = p + sra(a + b + p7, 4);
    end
    r.pressure = p;

    x = tf - 32'd76800;
    a = sra((ah << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
    b = sra(x * h6, 10);
    c = sra(x * h3, 11) + 32'd32768;
    d = sra(b * c, 10) + 32'd2097152;
    d = sra(d * h2 + 32'd8192, 14);
    x = a * d;
    c = sra(sra(x, 15) * sra(x, 15), 7);
    x = x - sra(c * h1, 4);
    if (x[31]) begin
      x = 32'd0;
    end
    if (x > 32'd419430400) begin
      x = 32'd419430400;
    end
    r.humidity = 17'(x >> 12);
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TEMP:    coef_regs[REG_TEMP]    = value & 64'hFFFF_FFFF_FFFF;
      REG_PRESS_A: coef_regs[REG_PRESS_A] = value;
      REG_PRESS_B: coef_regs[REG_PRESS_B] = value;
      REG_PRESS_9: coef_regs[REG_PRESS_9] = value & 64'hFFFF;
      REG_HUM_A:   coef_regs[REG_HUM_A]   = value & 64'hFF_FFFF_FFFF;
      REG_HUM_B:   coef_regs[REG_HUM_B]   = value & 64'hFF_FFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic send_sample(sample_row_t row);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row.ah, row.ap, row.at};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (row.typed) begin
      pending_readings.push_back(row.want);
    end else begin
      pending_readings.push_back(compensate(row.at, row.ap, row.ah));
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic sample_row_t random_row();
    sample_row_t row;
    int mode;
    mode = $urandom_range(0, 9);
    row.typed = 1'b0;
    row.want = '0;
    if (mode < 6) begin
      row.at = 20'($urandom_range(380000, 640000));
      row.ap = 20'($urandom_range(250000, 500000));
      row.ah = 16'($urandom_range(15000, 50000));
    end else if (mode < 9) begin
      row.at = 20'($urandom());
      row.ap = 20'($urandom());
      row.ah = 16'($urandom());
    end else begin
      row.at = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      row.ap = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      row.ah = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
    end
    return row;
  endfunction

  // Realistic calibration with small deviations, an extreme pattern or random values.
  task automatic load_phase_coefs(int phase);
    logic [63:0] v [6];
    case (phase % 5)
      0: begin
        v[0] = {16'hFC18 + 16'($urandom_range(0, 200)), 16'd26435, 16'd27504};
        v[1] = {16'd2855, 16'd3024, 16'hD643, 16'd36477 + 16'($urandom_range(0, 300))};
        v[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        v[3] = 64'd6000;
        v[4] = {8'd30, 8'd0, 16'd362, 8'd75};
        v[5] = {12'd50, 12'd324};
      end
      1: for (int i = 0; i < 6; i++) v[i] = '1;
      2: begin
        for (int i = 0; i < 6; i++) v[i] = rand64();
        v[1][15:0] = 16'd0;
      end
      3: for (int i = 0; i < 6; i++) v[i] = {4{16'h7FFF}};
      default: for (int i = 0; i < 6; i++) v[i] = rand64();
    endcase
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_e'(i), v[i]);
  endtask

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.temperature = out_tdata[31:0];
      got.pressure    = out_tdata[63:32];
      got.humidity    = out_tdata[80:64];
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (got.temperature !== want.temperature) begin
          $display("%0t: temperature expected %0d got %0d", $time,
                   want.temperature, got.temperature);
          errors++;
        end
        if (got.pressure !== want.pressure) begin
          $display("%0t: pressure expected %0d got %0d", $time,
                   want.pressure, got.pressure);
          errors++;
        end
        if (got.humidity !== want.humidity) begin
          $display("%0t: humidity expected %0d got %0d", $time,
                   want.humidity, got.humidity);
          errors++;
        end
        if (out_tdata[87:81] !== 7'd0) begin
          $display("%0t: fill bits expected 0 got %h", $time, out_tdata[87:81]);
          errors++;
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sample_row_t directed [12];
    reading_t zero_reading;
    zero_reading = '0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    for (int i = 0; i < 6; i++) coef_regs[i] = '0;

    // With every coefficient cleared the result is all zero and the divisor is zero.
    directed[0]  = '{20'h00000, 20'h00000, 16'h0000, 1'b1, zero_reading};
    directed[1]  = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, zero_reading};
    directed[2]  = '{20'h80000, 20'h80000, 16'h8000, 1'b1, zero_reading};
    directed[3]  = '{20'h7FFFF, 20'h7FFFF, 16'h7FFF, 1'b1, zero_reading};
    directed[4]  = '{20'd519888, 20'd415148, 16'd30000, 1'b0, zero_reading};
    directed[5]  = '{20'h00000, 20'h00000, 16'h0000, 1'b0, zero_reading};
    directed[6]  = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, zero_reading};
    directed[7]  = '{20'hFFFFF, 20'h00000, 16'h0000, 1'b0, zero_reading};
    directed[8]  = '{20'h00000, 20'hFFFFF, 16'hFFFF, 1'b0, zero_reading};
    directed[9]  = '{20'd420000, 20'd300000, 16'd20000, 1'b0, zero_reading};
    directed[10] = '{20'd600000, 20'd500000, 16'd40000, 1'b0, zero_reading};
    directed[11] = '{20'd550000, 20'd1, 16'hFFFF, 1'b0, zero_reading};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 12; i++) begin
      if (i == 4) begin
        stop_sending();
        drain_results();
        load_phase_coefs(0);
        write_reg(CFG_IDX_UNUSED, rand64());
      end
      send_sample(directed[i]);
    end

    for (int phase = 1; phase <= N_PHASES; phase++) begin
      stop_sending();
      drain_results();
      load_phase_coefs(phase);
      if (phase == N_PHASES) quiet = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 3 && n == 5) hold_req = 1'b1;
        send_sample(random_row());
      end
    end

    stop_sending();
    drain_results();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
